// File: rtl/lztsd_pkg.sv
// lztsd_pkg: shared constants and types for the lz tag stream decompressor
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package lztsd_pkg;
    localparam int RING_AW      = 12;
    localparam int SIZE_W       = 30;
    localparam int GROUP_BYTES  = 8;
    localparam int TAG_MIN_LEN  = 3;
    localparam int TAG_EXT_BASE = 18;
    localparam int CFG_IDX_W    = 1;

    localparam logic [CFG_IDX_W-1:0] REG_RAW_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_REQ_COMP = 1'b1;

    // copy request from parser to ring engine
    typedef struct packed {
        logic              start;
        logic [RING_AW-1:0] offset;
        logic [8:0]        len;
    } t_copy_req;
endpackage
`default_nettype wire

// File: rtl/lz_tag_stream_decompressor.sv
// lz_tag_stream_decompressor: top level, parser, copy engine and output grouping
// depends on lztsd_pkg and lztsd_ring
//
// usage: compressed bytes arrive on i_comp_byte/i_last_byte with valid/ready.
// each input transfer yields zero or more results on the output channel:
// groups of up to GROUP_BYTES decoded bytes, then a status result
// (o_stream_done) after the byte flagged last. o_run_last marks the final
// result of each input byte.
// the block works on one input byte at a time; ready is high only in idle.
// a control byte or an ignored byte passes through decode and flush back to
// idle; a literal also emits its result from flush. a tag byte that copies n
// bytes reads each byte from the ring, then writes it back, and emits each
// full group from the write state; a partial group at the end is emitted
// from flush. the byte flagged last adds the status result.
// when the receiver stalls, each result is held.
// reset (synchronous, active low) clears the stream state; raw_size resets to
// 0 and require_complete to 1. the ring contents are not cleared: offsets are
// checked against the produced count so unwritten entries are never read.
// configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data while idle.
`timescale 1ns / 1ps
`default_nettype none
module lz_tag_stream_decompressor #(
    parameter int GROUP_BYTES = lztsd_pkg::GROUP_BYTES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [lztsd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [29:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_comp_byte,
    input  wire logic        i_last_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [8*GROUP_BYTES-1:0] o_out_bytes,
    output logic [3:0]       o_byte_count,
    output logic             o_run_last,
    output logic             o_stream_done,
    output logic             o_error,
    output logic [29:0]      o_produced_total
);
    localparam int AW = lztsd_pkg::RING_AW;
    localparam int SW = lztsd_pkg::SIZE_W;

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_RD, S_WR, S_FLUSH, S_STATUS, S_OUT
    } t_state;

    t_state r_state, r_ret;
    logic [SW-1:0] r_raw_size;
    logic          r_req_comp;
    logic [AW-1:0] r_wpos;
    logic [SW-1:0] r_prod;
    logic [7:0]    r_ctrl;
    logic [3:0]    r_items;
    logic [1:0]    r_phase;
    logic [7:0]    r_tag1;
    logic [AW-1:0] r_toff;
    logic          r_err;
    logic          r_ovr;
    logic [7:0]    r_byte;
    logic          r_last;
    logic [8:0]    r_len;
    logic [8*GROUP_BYTES-1:0] r_acc;
    logic [3:0]    r_cnt;

    logic       ring_we;
    logic [7:0] ring_wdata;
    logic [7:0] ring_rdata;
    logic [AW-1:0] ring_raddr;
    logic [8:0] copy_len;
    logic [8*GROUP_BYTES-1:0] acc_next;

    lztsd_ring u_ring (
        .i_clk  (i_clk),
        .i_we   (ring_we),
        .i_waddr(r_wpos),
        .i_wdata(ring_wdata),
        .i_raddr(ring_raddr),
        .o_rdata(ring_rdata)
    );

    assign o_ready = (r_state == S_IDLE);
    assign ring_raddr = r_wpos - r_toff;

    // tag length for the current byte, clipped to the room left
    always_comb begin
        logic [SW-1:0] room;
        logic [SW-1:0] want;
        room = (r_raw_size > r_prod) ? r_raw_size - r_prod : '0;
        if (r_phase == 2'd1) begin
            want = SW'(r_tag1[3:0]) + SW'(lztsd_pkg::TAG_MIN_LEN);
        end else begin
            want = SW'(r_byte) + SW'(lztsd_pkg::TAG_EXT_BASE);
        end
        copy_len = (want > room) ? room[8:0] : want[8:0];
    end

    wire [AW-1:0] tag_off_now = {r_tag1[7:4], r_byte};
    wire          off_bad = (r_toff == '0) || (SW'(r_toff) > r_prod);
    wire          off_bad_now = (tag_off_now == '0) || (SW'(tag_off_now) > r_prod);
    wire          copy_go = (r_phase == 2'd1)
                            ? (r_tag1[3:0] != 4'hf && !off_bad_now && copy_len != '0)
                            : (r_phase == 2'd2) ? (!off_bad && copy_len != '0) : 1'b0;
    wire          grp_full = (r_cnt + 1'b1 == 4'(GROUP_BYTES));

    always_comb begin
        ring_we    = 1'b0;
        ring_wdata = r_byte;
        if (r_state == S_DECODE && !r_err && r_phase == 2'd0
            && r_prod < r_raw_size && r_items != 4'd0 && !r_ctrl[0]) begin
            ring_we = 1'b1;
        end else if (r_state == S_WR) begin
            ring_we    = 1'b1;
            ring_wdata = ring_rdata;
        end
    end

    always_comb begin
        acc_next = r_acc;
        acc_next[8*r_cnt[2:0] +: 8] = ring_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ret      <= S_IDLE;
            r_raw_size <= '0;
            r_req_comp <= 1'b1;
            r_wpos     <= '0;
            r_prod     <= '0;
            r_ctrl     <= '0;
            r_items    <= '0;
            r_phase    <= '0;
            r_tag1     <= '0;
            r_toff     <= '0;
            r_err      <= 1'b0;
            r_ovr      <= 1'b0;
            r_cnt      <= '0;
            r_acc      <= '0;
            o_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    lztsd_pkg::REG_RAW_SIZE: r_raw_size <= i_cfg_data;
                    lztsd_pkg::REG_REQ_COMP: r_req_comp <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (ring_we) begin
                r_wpos <= r_wpos + 1'b1;
                r_prod <= r_prod + 1'b1;
                // a full group inside a copy leaves straight from the write state
                if (r_state == S_WR && grp_full) begin
                    r_acc <= '0;
                    r_cnt <= '0;
                end else begin
                    r_acc <= acc_next;
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_byte  <= i_comp_byte;
                        r_last  <= i_last_byte;
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_state <= (!r_err && copy_go) ? S_RD : S_FLUSH;
                    r_len   <= copy_len;
                    if (!r_err) begin
                        if (r_phase == 2'd1) begin
                            r_toff <= tag_off_now;
                            if (r_tag1[3:0] == 4'hf) begin
                                r_phase <= 2'd2;
                            end else begin
                                r_phase <= 2'd0;
                                r_ctrl  <= r_ctrl >> 1;
                                if (r_items != 0) r_items <= r_items - 1'b1;
                                if (off_bad_now) r_err <= 1'b1;
                            end
                        end else if (r_phase == 2'd2) begin
                            r_phase <= 2'd0;
                            r_ctrl  <= r_ctrl >> 1;
                            if (r_items != 0) r_items <= r_items - 1'b1;
                            if (off_bad) r_err <= 1'b1;
                        end else if (r_prod >= r_raw_size) begin
                            r_ovr <= 1'b1;
                        end else if (r_items == 0) begin
                            r_ctrl  <= r_byte;
                            r_items <= 4'd8;
                        end else if (r_ctrl[0]) begin
                            r_tag1  <= r_byte;
                            r_phase <= 2'd1;
                        end else begin
                            r_ctrl <= r_ctrl >> 1;
                            r_items <= r_items - 1'b1;
                        end
                    end
                end
                S_RD: begin
                    // ring read issued this cycle, data next cycle
                    r_state <= S_WR;
                end
                S_WR: begin
                    r_len <= r_len - 1'b1;
                    if (grp_full) begin
                        r_ret   <= (r_len == 9'd1) ? S_FLUSH : S_RD;
                        r_state <= S_OUT;
                        o_valid <= 1'b1;
                        o_byte_count  <= 4'(GROUP_BYTES);
                        o_out_bytes   <= acc_next;
                        o_stream_done <= 1'b0;
                        o_error       <= 1'b0;
                        o_produced_total <= '0;
                        o_run_last    <= (r_len == 9'd1) && !r_last;
                    end else begin
                        r_state <= (r_len == 9'd1) ? S_FLUSH : S_RD;
                    end
                end
                S_FLUSH: begin
                    if (r_cnt != 0) begin
                        o_valid <= 1'b1;
                        o_byte_count  <= r_cnt;
                        o_out_bytes   <= r_acc;
                        o_stream_done <= 1'b0;
                        o_error       <= 1'b0;
                        o_produced_total <= '0;
                        o_run_last    <= !r_last;
                        r_ret   <= r_last ? S_STATUS : S_IDLE;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= r_last ? S_STATUS : S_IDLE;
                    end
                end
                S_STATUS: begin
                    o_valid <= 1'b1;
                    o_byte_count  <= '0;
                    o_out_bytes   <= '0;
                    o_stream_done <= 1'b1;
                    o_error <= r_err || (r_phase != 2'd0)
                            || (r_req_comp && ((r_prod != r_raw_size) || r_ovr));
                    o_produced_total <= r_prod;
                    o_run_last <= 1'b1;
                    r_ret   <= S_IDLE;
                    r_state <= S_OUT;
                    r_wpos  <= '0;
                    r_prod  <= '0;
                    r_ctrl  <= '0;
                    r_items <= '0;
                    r_phase <= '0;
                    r_tag1  <= '0;
                    r_toff  <= '0;
                    r_err   <= 1'b0;
                    r_ovr   <= 1'b0;
                end
                S_OUT: begin
                    if (i_ready) begin
                        o_valid <= 1'b0;
                        r_acc   <= '0;
                        r_cnt   <= '0;
                        r_state <= r_ret;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 4'(GROUP_BYTES)) else $error("group count overflow");
    a_ready_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("input taken while result pending");
    a_status_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_stream_done) |-> (o_byte_count == 4'd0 && o_run_last))
        else $error("bad status result");
`endif
endmodule
`default_nettype wire

// File: rtl/lztsd_ring.sv
// lztsd_ring: 4096 x 8 history memory, one write and one registered read port
// depends on lztsd_pkg
`timescale 1ns / 1ps
`default_nettype none
module lztsd_ring (
    input  wire logic                         i_clk,
    input  wire logic                         i_we,
    input  wire logic [lztsd_pkg::RING_AW-1:0] i_waddr,
    input  wire logic [7:0]                   i_wdata,
    input  wire logic [lztsd_pkg::RING_AW-1:0] i_raddr,
    output logic      [7:0]                   o_rdata
);
    logic [7:0] r_mem [0:(1<<lztsd_pkg::RING_AW)-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire
